// ===== design/mksd_pkg.sv =====
package mksd_pkg;

   // field widths
   localparam int CMD_W   = 8;
   localparam int ENC_W   = 16;
   localparam int TIME_W  = 32;
   localparam int PCT_W   = 7;
   localparam int DUTY_W  = 8;
   localparam int THR_W   = 16;
   localparam int KLEN_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // full-scale duty in percent
   localparam int DUTY_FULL = 100;

   // divider geometry: |cmd| * 100 fits in 14 bits, two quotient bits per cycle
   localparam int NUM_W         = 14;
   localparam int BITS_PER_STEP = 2;
   localparam int DIV_STEPS     = NUM_W / BITS_PER_STEP;
   localparam int CNT_W         = $clog2(DIV_STEPS);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_MAX   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_MIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROLL_THR    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_RUN_PCT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KICK_PCT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KICK_LEN_MS = 3'd5;

   // register reset values
   localparam logic [PCT_W-1:0]  RST_SPEED_MAX   = 7'd30;
   localparam logic [CMD_W-1:0]  RST_SPEED_MIN   = 8'hE2;
   localparam logic [THR_W-1:0]  RST_ROLL_THR    = 16'd2;
   localparam logic [PCT_W-1:0]  RST_MIN_RUN_PCT = 7'd20;
   localparam logic [PCT_W-1:0]  RST_KICK_PCT    = 7'd60;
   localparam logic [KLEN_W-1:0] RST_KICK_LEN_MS = 16'd150;

   typedef struct packed {
      logic [PCT_W-1:0]  speed_max;
      logic [CMD_W-1:0]  speed_min;
      logic [THR_W-1:0]  rolling_threshold;
      logic [PCT_W-1:0]  min_run_pct;
      logic [PCT_W-1:0]  kick_pct;
      logic [KLEN_W-1:0] kick_len_ms;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic ack;
   } lane_ctl_type;

   typedef struct packed {
      logic              done;
      logic [DUTY_W-1:0] duty;
      logic              rolling;
   } lane_out_type;

   typedef enum logic [1:0] {
      L_IDLE,
      L_DIV,
      L_FIN,
      L_DONE
   } lane_state_type;

   typedef enum logic {
      T_IDLE,
      T_BUSY
   } top_state_type;

endpackage

// ===== design/mksd_req_if.sv =====
interface mksd_req_if import mksd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CMD_W-1:0]  cmd_left;
   logic signed [CMD_W-1:0]  cmd_right;
   logic signed [ENC_W-1:0]  enc_step_left;
   logic signed [ENC_W-1:0]  enc_step_right;
   logic                     drive_enable;
   logic                     safe_ok;
   logic [TIME_W-1:0]        time_ms;

   modport source (
      output valid, cmd_left, cmd_right, enc_step_left, enc_step_right,
             drive_enable, safe_ok, time_ms,
      input  ready
   );

   modport sink (
      input  valid, cmd_left, cmd_right, enc_step_left, enc_step_right,
             drive_enable, safe_ok, time_ms,
      output ready
   );
endinterface

// ===== design/mksd_rsp_if.sv =====
interface mksd_rsp_if import mksd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DUTY_W-1:0] pwm_left;
   logic signed [DUTY_W-1:0] pwm_right;
   logic                     pwm_written;
   logic                     rolling_left;
   logic                     rolling_right;

   modport source (
      output valid, pwm_left, pwm_right, pwm_written, rolling_left, rolling_right,
      input  ready
   );

   modport sink (
      input  valid, pwm_left, pwm_right, pwm_written, rolling_left, rolling_right,
      output ready
   );
endinterface

// ===== design/mksd_lane.sv =====
module mksd_lane import mksd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  lane_ctl_type            ctl,
   input  logic signed [CMD_W-1:0] cmd,
   input  logic signed [ENC_W-1:0] enc_step,
   input  logic [TIME_W-1:0]       now,
   input  logic                    written,
   output lane_out_type            status
);

   lane_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PCT_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [PCT_W-1:0]  div_ff, div_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;
   logic              rolling_ff, rolling_in;
   logic              written_ff, written_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] kick_end_ff, kick_end_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;

   // clamp, magnitude and scaled dividend of the incoming command
   logic signed [CMD_W-1:0] max_s;
   logic signed [CMD_W-1:0] clamp_s;
   logic [CMD_W-1:0]        abs_s;
   logic [NUM_W-1:0]        prod;
   logic [PCT_W-1:0]        divisor;
   logic [ENC_W-1:0]        enc_abs;
   logic                    rolling_now;

   always_comb begin
      max_s   = $signed({1'b0, cfg.speed_max});
      clamp_s = (cmd > max_s) ? max_s : cmd;
      if (clamp_s < $signed(cfg.speed_min)) begin
         clamp_s = $signed(cfg.speed_min);
      end
      abs_s       = clamp_s[CMD_W-1] ? (~clamp_s + 8'd1) : clamp_s;
      prod        = NUM_W'(abs_s) * NUM_W'(DUTY_FULL);
      divisor     = (cfg.speed_max == '0) ? 7'd1 : cfg.speed_max;
      enc_abs     = enc_step[ENC_W-1] ? (~enc_step + 16'd1) : enc_step;
      rolling_now = enc_abs > cfg.rolling_threshold;
   end

   // restoring divider, two quotient bits per cycle
   logic [PCT_W-1:0] step_rem;
   logic [NUM_W-1:0] step_quo;
   logic [PCT_W:0]   trial;

   always_comb begin
      step_rem = rem_ff;
      step_quo = quo_ff;
      trial    = '0;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         trial    = {step_rem, step_quo[NUM_W-1]};
         step_quo = {step_quo[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            trial       = trial - {1'b0, div_ff};
            step_quo[0] = 1'b1;
         end
         step_rem = trial[PCT_W-1:0];
      end
   end

   // duty floors, kick window and final saturation
   logic [PCT_W-1:0]         mag_q;
   logic [TIME_W-1:0]        end_armed;
   logic [TIME_W-1:0]        end_eff;
   logic [PCT_W-1:0]         floor_pct;
   logic [PCT_W-1:0]         mag_f;
   logic [PCT_W-1:0]         mag;
   logic signed [DUTY_W-1:0] duty_val;

   always_comb begin
      mag_q     = (quo_ff > NUM_W'(DUTY_FULL)) ? PCT_W'(DUTY_FULL) : quo_ff[PCT_W-1:0];
      end_armed = now_ff + TIME_W'(cfg.kick_len_ms);
      end_eff   = (kick_end_ff == '0) ? end_armed : kick_end_ff;
      if (rolling_ff) begin
         floor_pct = cfg.min_run_pct;
      end else if (now_ff < end_eff) begin
         floor_pct = cfg.kick_pct;
      end else begin
         floor_pct = cfg.min_run_pct;
      end
      mag_f = (mag_q < floor_pct) ? floor_pct : mag_q;
      mag   = (mag_f > PCT_W'(DUTY_FULL)) ? PCT_W'(DUTY_FULL) : mag_f;
      if (neg_ff && (quo_ff != '0)) begin
         duty_val = -$signed({1'b0, mag});
      end else begin
         duty_val = $signed({1'b0, mag});
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= L_IDLE;
         cnt_ff      <= '0;
         kick_end_ff <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         kick_end_ff <= kick_end_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      div_ff     <= div_in;
      neg_ff     <= neg_in;
      zero_ff    <= zero_in;
      rolling_ff <= rolling_in;
      written_ff <= written_in;
      now_ff     <= now_in;
      duty_ff    <= duty_in;
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      div_in      = div_ff;
      neg_in      = neg_ff;
      zero_in     = zero_ff;
      rolling_in  = rolling_ff;
      written_in  = written_ff;
      now_in      = now_ff;
      kick_end_in = kick_end_ff;
      duty_in     = duty_ff;

      case (state_ff)
         L_IDLE, L_DONE: begin
            if (ctl.start) begin
               state_in   = L_DIV;
               cnt_in     = CNT_W'(DIV_STEPS - 1);
               rem_in     = '0;
               quo_in     = prod;
               div_in     = divisor;
               neg_in     = clamp_s[CMD_W-1];
               zero_in    = (clamp_s == '0);
               rolling_in = rolling_now;
               written_in = written;
               now_in     = now;
            end else if (ctl.ack) begin
               state_in = L_IDLE;
            end
         end
         L_DIV: begin
            rem_in = step_rem;
            quo_in = step_quo;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = L_FIN;
            end
         end
         L_FIN: begin
            state_in = L_DONE;
            if (!written_ff || zero_ff) begin
               duty_in = '0;
            end else begin
               duty_in = duty_val;
            end
            if (written_ff) begin
               if (zero_ff || rolling_ff) begin
                  kick_end_in = '0;
               end else begin
                  kick_end_in = end_eff;
               end
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   assign status.done    = (state_ff == L_DONE);
   assign status.duty    = duty_ff;
   assign status.rolling = rolling_ff;

endmodule

// ===== design/motor_kick_start_duty.sv =====
// Path: an accepted req word runs through the per-lane restoring divider,
//   the floor/kick step and the output load to reach its rsp word.
// Flow: no new word while the lanes divide; the next word is taken in the
//   cycle its predecessor moves to the output, which a stalled rsp holds off.
// Reset: synchronous, active high; registers return to defaults, kicks disarmed.
module motor_kick_start_duty import mksd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mksd_req_if.sink              req_chan,
   mksd_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_SPEED_MAX:   cfg_in.speed_max         = csr_wdata[PCT_W-1:0];
            REG_SPEED_MIN:   cfg_in.speed_min         = csr_wdata[CMD_W-1:0];
            REG_ROLL_THR:    cfg_in.rolling_threshold = csr_wdata[THR_W-1:0];
            REG_MIN_RUN_PCT: cfg_in.min_run_pct       = csr_wdata[PCT_W-1:0];
            REG_KICK_PCT:    cfg_in.kick_pct          = csr_wdata[PCT_W-1:0];
            REG_KICK_LEN_MS: cfg_in.kick_len_ms       = csr_wdata[KLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_max         <= RST_SPEED_MAX;
         cfg_ff.speed_min         <= RST_SPEED_MIN;
         cfg_ff.rolling_threshold <= RST_ROLL_THR;
         cfg_ff.min_run_pct       <= RST_MIN_RUN_PCT;
         cfg_ff.kick_pct          <= RST_KICK_PCT;
         cfg_ff.kick_len_ms       <= RST_KICK_LEN_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // control state and output word register
   top_state_type     state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0] pwm_left_ff, pwm_left_in;
   logic [DUTY_W-1:0] pwm_right_ff, pwm_right_in;
   logic              written_ff, written_in;
   logic              rsp_written_ff, rsp_written_in;
   logic              roll_l_ff, roll_l_in;
   logic              roll_r_ff, roll_r_in;

   lane_out_type lane_l;
   lane_out_type lane_r;
   lane_ctl_type lane_ctl;

   logic lanes_done;
   logic out_free;
   logic load;
   logic accept;
   logic written_now;

   assign lanes_done  = lane_l.done && lane_r.done;
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign load        = (state_ff == T_BUSY) && lanes_done && out_free;
   assign req_chan.ready = (state_ff == T_IDLE) || load;
   assign accept      = req_chan.valid && req_chan.ready;
   assign written_now = req_chan.drive_enable && req_chan.safe_ok;

   assign lane_ctl.start = accept;
   assign lane_ctl.ack   = load;

   // one lane per wheel
   mksd_lane u_lane_left (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .ctl      (lane_ctl),
      .cmd      (req_chan.cmd_left),
      .enc_step (req_chan.enc_step_left),
      .now      (req_chan.time_ms),
      .written  (written_now),
      .status   (lane_l)
   );

   mksd_lane u_lane_right (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .ctl      (lane_ctl),
      .cmd      (req_chan.cmd_right),
      .enc_step (req_chan.enc_step_right),
      .now      (req_chan.time_ms),
      .written  (written_now),
      .status   (lane_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pwm_left_ff    <= pwm_left_in;
      pwm_right_ff   <= pwm_right_in;
      written_ff     <= written_in;
      rsp_written_ff <= rsp_written_in;
      roll_l_ff      <= roll_l_in;
      roll_r_ff      <= roll_r_in;
   end

   // merge lane results into the output word
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      pwm_left_in    = pwm_left_ff;
      pwm_right_in   = pwm_right_ff;
      written_in     = written_ff;
      rsp_written_in = rsp_written_ff;
      roll_l_in      = roll_l_ff;
      roll_r_in      = roll_r_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in   = 1'b1;
         pwm_left_in    = lane_l.duty;
         pwm_right_in   = lane_r.duty;
         rsp_written_in = written_ff;
         roll_l_in      = lane_l.rolling;
         roll_r_in      = lane_r.rolling;
      end

      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               state_in = T_BUSY;
            end
         end
         T_BUSY: begin
            if (load && !accept) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase

      if (accept) begin
         written_in = written_now;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pwm_left      = pwm_left_ff;
   assign rsp_chan.pwm_right     = pwm_right_ff;
   assign rsp_chan.pwm_written   = rsp_written_ff;
   assign rsp_chan.rolling_left  = roll_l_ff;
   assign rsp_chan.rolling_right = roll_r_ff;

`ifndef SYNTHESIS
   // both lanes run in lockstep
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      lane_l.done == lane_r.done)
      else $error("lane done flags diverged");

   // an unwritten word carries zero duty
   a_unwritten_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.pwm_written) |->
         (rsp_chan.pwm_left == '0) && (rsp_chan.pwm_right == '0))
      else $error("nonzero duty on unwritten word");

   // duty magnitude never exceeds full scale
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         ($signed(rsp_chan.pwm_left) <= 8'sd100) && ($signed(rsp_chan.pwm_left) >= -8'sd100) &&
         ($signed(rsp_chan.pwm_right) <= 8'sd100) && ($signed(rsp_chan.pwm_right) >= -8'sd100))
      else $error("duty out of range");

   // no new word taken while the lanes are still dividing
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == T_BUSY) && !lanes_done) |-> !req_chan.ready)
      else $error("req accepted while lanes busy");
`endif

endmodule
